// ===== rtl/fcr2d_pkg.sv =====
// Package for the 2D friction cone residual unit.
// Holds fixed-point widths, the sequencer state type and the status codes.
// Depends on nothing.
package fcr2d_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	localparam int MU_W      = FRAC_BITS + 2;
	localparam int CW        = 40;
	localparam int MA_W      = 36;
	localparam int PROD_W    = 2 * MA_W;
	localparam int NUM_W     = 36;
	localparam int SUM_W     = 64;
	localparam int DVD_W     = SUM_W + 2 * FRAC_BITS;
	localparam int CNT_W     = $clog2(DVD_W + 1);
	localparam int S_RAW_W   = 6 * DW + MU_W;
	localparam int S_DATA_W  = ((S_RAW_W + 7) / 8) * 8;
	localparam int M_DATA_W  = 40;
	localparam int STAT_W    = 2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EXCEED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_QZERO  = 2'd2;

	localparam logic [DW-1:0] TOL_RESET = 32'd65;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MWT,
		ST_MT1,
		ST_MT0,
		ST_MMU,
		ST_DECIDE,
		ST_DIV_RN,
		ST_MRT,
		ST_RT,
		ST_SQ_ZN,
		ST_SQ_ZT,
		ST_SQ_QN,
		ST_SQ_QT,
		ST_SQ_END,
		ST_FINAL,
		ST_DIV_ERR,
		ST_SQ_LOAD,
		ST_SQRT,
		ST_SQ_DONE,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/friction_cone_residual_2d_unit.sv =====
// Top level of the 2D friction cone residual unit.
// Uses fcr2d_pkg for widths, state type and status codes.
// A contact request is taken only when the unit is idle. A contact that projects inside or onto
// the polar cone skips the division; one on the boundary runs the restoring divider, which
// produces one quotient bit per cycle. The contact marked last then runs the divider for the
// final quotient and the square root, or skips both when the q norm is zero, and may wait for
// the previous result to be taken. All products go through one registered multiplier. The
// result sits in an output register, so the next problem may start while it waits to be
// taken.
module friction_cone_residual_2d_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// reaction_normal, reaction_tangent, velocity_normal, velocity_tangent,
	// friction_coeff, offset_normal, offset_tangent, zero fill
	input  logic [fcr2d_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// relative_error, status, zero fill
	output logic [fcr2d_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fcr2d_pkg::DW-1:0]       cfg_data
);
	import fcr2d_pkg::*;

	localparam logic [SUM_W-1:0] SAT = {SUM_W{1'b1}};

	function automatic logic signed [CW-1:0] sx(input logic [DW-1:0] v);
		sx = {{(CW-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic [CW-1:0] magc(input logic signed [CW-1:0] v);
		magc = v[CW-1] ? -v : v;
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[SUM_W] ? SAT : s[SUM_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [DW-1:0]          tol_q;
	logic [DW-1:0]          zn_q, zt_q, wn_q, wt_q, qn_q, qt_q;
	logic [MU_W-1:0]        mu_q;
	logic                   last_q;
	logic signed [CW-1:0]   t0_q, t1_q, p_q, m0_q, rn_q, rt_q;
	logic [PROD_W-1:0]      mul_q;
	logic                   big_q;
	logic [SUM_W-1:0]       res_q, qsum_q;
	logic [DVD_W-1:0]       dvd_q;
	logic [SUM_W-1:0]       dvs_q, rem_q, quo_q;
	logic                   ovf_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       x_q, r_q, bit_q;
	logic [DW-1:0]          err_q;
	logic [STAT_W-1:0]      stat_q;
	logic                   m_valid_q;
	logic [M_DATA_W-1:0]    m_data_q;

	logic [MA_W-1:0]        mul_a, mul_b;
	logic [CW-1:0]          sq_mag;
	logic                   sq_big;
	logic [SUM_W-1:0]       addend;
	logic [SUM_W:0]         rem_sh;
	logic                   div_ge;
	logic [SUM_W-1:0]       rem_nx;
	logic [SUM_W-1:0]       trial;
	logic                   sq_ge;
	logic signed [CW-1:0]   prod_sh;
	logic signed [CW-1:0]   t1_mag;
	logic                   polar, boundary;
	logic                   out_free;
	logic                   accept;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_free  = !m_valid_q || m_tready;

	assign prod_sh  = mul_q[FRAC_BITS +: CW];
	assign t1_mag   = magc(t1_q);
	assign polar    = (p_q <= -t0_q);
	assign boundary = (t1_mag > m0_q);
	assign addend   = big_q ? SAT : mul_q[SUM_W-1:0];

	// Restoring divider step, one quotient bit.
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign div_ge = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = div_ge ? (rem_sh[SUM_W-1:0] - dvs_q) : rem_sh[SUM_W-1:0];

	// Square root step, one result bit.
	assign trial = r_q + bit_q;
	assign sq_ge = (x_q >= trial);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a  = '0;
		mul_b  = MA_W'(mu_q);
		sq_mag = '0;
		case (state_q)
			ST_SQ_ZN: sq_mag = magc(sx(zn_q) - rn_q);
			ST_SQ_ZT: sq_mag = magc(sx(zt_q) - rt_q);
			ST_SQ_QN: sq_mag = magc(sx(qn_q));
			ST_SQ_QT: sq_mag = magc(sx(qt_q));
			default: sq_mag = '0;
		endcase
		sq_big = |sq_mag[CW-1:DW];
		case (state_q)
			ST_MWT: mul_a = MA_W'(magc(sx(wt_q)));
			ST_MT1: mul_a = t1_mag[MA_W-1:0];
			ST_MT0: mul_a = MA_W'(magc(t0_q));
			ST_MMU: mul_a = MA_W'(mu_q);
			ST_MRT: mul_a = quo_q[MA_W-1:0];
			ST_SQ_ZN, ST_SQ_ZT, ST_SQ_QN, ST_SQ_QT: begin
				mul_a = MA_W'(sq_mag[DW-1:0]);
				mul_b = MA_W'(sq_mag[DW-1:0]);
			end
			default: mul_a = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (accept) state_d = ST_MWT;
			ST_MWT:     state_d = ST_MT1;
			ST_MT1:     state_d = ST_MT0;
			ST_MT0:     state_d = ST_MMU;
			ST_MMU:     state_d = ST_DECIDE;
			ST_DECIDE:  state_d = (!polar && boundary) ? ST_DIV_RN : ST_SQ_ZN;
			ST_DIV_RN:  if (cnt_q == CNT_W'(1)) state_d = ST_MRT;
			ST_MRT:     state_d = ST_RT;
			ST_RT:      state_d = ST_SQ_ZN;
			ST_SQ_ZN:   state_d = ST_SQ_ZT;
			ST_SQ_ZT:   state_d = ST_SQ_QN;
			ST_SQ_QN:   state_d = ST_SQ_QT;
			ST_SQ_QT:   state_d = ST_SQ_END;
			ST_SQ_END:  state_d = last_q ? ST_FINAL : ST_IDLE;
			ST_FINAL:   state_d = (qsum_q == '0) ? ST_EMIT : ST_DIV_ERR;
			ST_DIV_ERR: if (cnt_q == CNT_W'(1)) state_d = ST_SQ_LOAD;
			ST_SQ_LOAD: state_d = ST_SQRT;
			ST_SQRT:    if (bit_q == SUM_W'(1)) state_d = ST_SQ_DONE;
			ST_SQ_DONE: state_d = ST_EMIT;
			ST_EMIT:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= TOL_RESET;
			res_q     <= '0;
			qsum_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) tol_q <= cfg_data;
			if (state_q == ST_EMIT && out_free) m_valid_q <= 1'b1;
			else if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			case (state_q)
				ST_SQ_ZT, ST_SQ_QN: res_q <= sat_add(res_q, addend);
				ST_SQ_QT, ST_SQ_END: qsum_q <= sat_add(qsum_q, addend);
				ST_EMIT: begin
					if (out_free) begin
						res_q  <= '0;
						qsum_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		big_q <= sq_big;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					zn_q   <= s_tdata[0*DW +: DW];
					zt_q   <= s_tdata[1*DW +: DW];
					wn_q   <= s_tdata[2*DW +: DW];
					wt_q   <= s_tdata[3*DW +: DW];
					mu_q   <= s_tdata[4*DW +: MU_W];
					qn_q   <= s_tdata[4*DW+MU_W +: DW];
					qt_q   <= s_tdata[5*DW+MU_W +: DW];
					last_q <= s_tlast;
					t1_q   <= sx(s_tdata[1*DW +: DW]) - sx(s_tdata[3*DW +: DW]);
				end
			end
			ST_MT1: t0_q <= sx(zn_q) - sx(wn_q) - prod_sh;
			ST_MT0: p_q <= prod_sh;
			ST_MMU: m0_q <= t0_q[CW-1] ? -prod_sh : prod_sh;
			ST_DECIDE: begin
				if (polar) begin
					rn_q <= '0;
					rt_q <= '0;
				end else if (!boundary) begin
					rn_q <= t0_q;
					rt_q <= t1_q;
				end
				dvs_q <= SUM_W'(mul_q[PROD_W-1:FRAC_BITS]) + (SUM_W'(1) << FRAC_BITS);
				dvd_q <= {NUM_W'(p_q + t0_q), {(DVD_W-NUM_W){1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= CNT_W'(NUM_W + FRAC_BITS);
			end
			ST_DIV_RN, ST_DIV_ERR: begin
				rem_q <= rem_nx;
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[SUM_W-2:0], div_ge};
				ovf_q <= ovf_q | quo_q[SUM_W-1];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_MRT: rn_q <= CW'(quo_q[NUM_W-1:0]);
			ST_RT: begin
				if (t1_q[CW-1]) rt_q <= -prod_sh;
				else if (t1_q == '0) rt_q <= '0;
				else rt_q <= prod_sh;
			end
			ST_FINAL: begin
				err_q  <= '0;
				stat_q <= STAT_QZERO;
				dvs_q  <= qsum_q;
				dvd_q  <= {res_q, {(2*FRAC_BITS){1'b0}}};
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				cnt_q  <= CNT_W'(DVD_W);
			end
			ST_SQ_LOAD: begin
				x_q   <= ovf_q ? SAT : quo_q;
				r_q   <= '0;
				bit_q <= SUM_W'(1) << (SUM_W - 2);
			end
			ST_SQRT: begin
				if (sq_ge) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_SQ_DONE: begin
				err_q  <= r_q[DW-1:0];
				stat_q <= (r_q[DW-1:0] > tol_q) ? STAT_EXCEED : STAT_OK;
			end
			ST_EMIT: begin
				if (out_free) m_data_q <= M_DATA_W'({stat_q, err_q});
			end
			default: ;
		endcase
	end

	// A new result only comes out of the emit state.
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_EMIT)
		else $error("result raised outside emit");

	// The sums are cleared together with each result.
	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (res_q == '0) && (qsum_q == '0))
		else $error("sums not cleared with result");

	// The divider never runs with an exhausted count.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_RN || state_q == ST_DIV_ERR) |-> cnt_q != '0)
		else $error("divider count underflow");

	// A zero q norm always reports a zero error.
	a_qzero_err: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[DW +: STAT_W] == STAT_QZERO) |-> m_tdata[DW-1:0] == '0)
		else $error("q norm zero with nonzero error");

endmodule
